// ===== rtl/arsrch_pkg.sv =====
// ----------------------------------------------------------------------------
// arsrch_pkg
// Shared widths, command codes and the microcode table of the table search
// engine.
// ----------------------------------------------------------------------------
package arsrch_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned LenW       = AddrW + 1;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned InTdataW   = ((AddrW + DataW + 7) / 8) * 8;
  localparam int unsigned OutTdataW  = 8;
  localparam int unsigned PcW        = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_REVERSE = 2'd1,
    CMD_LINEAR  = 2'd2,
    CMD_BINARY  = 2'd3
  } cmd_e;

  // datapath actions, one per control word
  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_WRITE     = 4'd1,
    ACT_RD_LO     = 4'd2,
    ACT_RD_HI     = 4'd3,
    ACT_WR_LO     = 4'd4,
    ACT_WR_HI     = 4'd5,
    ACT_LO_INC    = 4'd6,
    ACT_PROBE     = 4'd7,
    ACT_MOVE      = 4'd8,
    ACT_EMIT_HIT  = 4'd9,
    ACT_EMIT_MISS = 4'd10
  } act_e;

  // jump conditions: taken goes to jt, else to jn; a taken dispatch goes to the command's entry step
  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_DISPATCH = 3'd1,
    COND_NOT_LT   = 3'd2,
    COND_NOT_LE   = 3'd3,
    COND_EQ       = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_e;

  typedef logic [PcW-1:0] pc_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   jt;
    pc_t   jn;
  } uword_t;

  // step addresses
  localparam pc_t StIdle = 4'd0;
  localparam pc_t StWr   = 4'd1;
  localparam pc_t StRv0  = 4'd2;
  localparam pc_t StRv1  = 4'd3;
  localparam pc_t StRv2  = 4'd4;
  localparam pc_t StRv3  = 4'd5;
  localparam pc_t StLs0  = 4'd6;
  localparam pc_t StLs1  = 4'd7;
  localparam pc_t StBs0  = 4'd8;
  localparam pc_t StBs1  = 4'd9;
  localparam pc_t StHit  = 4'd10;
  localparam pc_t StMiss = 4'd11;

  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, jt: StIdle, jn: StIdle};
    case (pc)
      StIdle: w = '{act: ACT_NONE,      cond: COND_DISPATCH, jt: StIdle, jn: StIdle};
      StWr:   w = '{act: ACT_WRITE,     cond: COND_ALWAYS,   jt: StIdle, jn: StIdle};
      StRv0:  w = '{act: ACT_RD_LO,     cond: COND_NOT_LT,   jt: StIdle, jn: StRv1};
      StRv1:  w = '{act: ACT_RD_HI,     cond: COND_ALWAYS,   jt: StRv2,  jn: StRv2};
      StRv2:  w = '{act: ACT_WR_LO,     cond: COND_ALWAYS,   jt: StRv3,  jn: StRv3};
      StRv3:  w = '{act: ACT_WR_HI,     cond: COND_ALWAYS,   jt: StRv0,  jn: StRv0};
      StLs0:  w = '{act: ACT_RD_LO,     cond: COND_NOT_LE,   jt: StMiss, jn: StLs1};
      StLs1:  w = '{act: ACT_LO_INC,    cond: COND_EQ,       jt: StHit,  jn: StLs0};
      StBs0:  w = '{act: ACT_PROBE,     cond: COND_NOT_LE,   jt: StMiss, jn: StBs1};
      StBs1:  w = '{act: ACT_MOVE,      cond: COND_EQ,       jt: StHit,  jn: StBs0};
      StHit:  w = '{act: ACT_EMIT_HIT,  cond: COND_OUT_BUSY, jt: StHit,  jn: StIdle};
      StMiss: w = '{act: ACT_EMIT_MISS, cond: COND_OUT_BUSY, jt: StMiss, jn: StIdle};
      default: w = '{act: ACT_NONE,     cond: COND_ALWAYS,   jt: StIdle, jn: StIdle};
    endcase
    return w;
  endfunction

  function automatic pc_t entry_step(cmd_e cmd);
    pc_t pc;
    case (cmd)
      CMD_WRITE:   pc = StWr;
      CMD_REVERSE: pc = StRv0;
      CMD_LINEAR:  pc = StLs0;
      CMD_BINARY:  pc = StBs0;
      default:     pc = StIdle;
    endcase
    return pc;
  endfunction

  // signed compare of two bounds; lo is never negative, hi may be -1
  function automatic logic bound_le(logic [LenW-1:0] lo, logic [LenW-1:0] hi);
    return $signed({1'b0, lo}) <= $signed({hi[LenW-1], hi});
  endfunction

  function automatic logic bound_lt(logic [LenW-1:0] lo, logic [LenW-1:0] hi);
    return $signed({1'b0, lo}) < $signed({hi[LenW-1], hi});
  endfunction

endpackage

// ===== rtl/array_reverse_and_search_engine.sv =====
// ----------------------------------------------------------------------------
// array_reverse_and_search_engine
// Word table with write, in-place reverse, linear search and binary search,
// run by a small microcoded sequencer over a single-port-read table memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group: tuser carries the command, tdata the
//   entry index and the data word (write value or search key). Only the two
//   search commands return a response on the m_axis group, one found bit.
//   cfg_we_i / cfg_wdata_i set the number of table entries in use.
// Sequence (one request at a time, s_axis_tready_o is high while idle):
//   write              one write step after the accept
//   reverse            per swapped pair: read low, read high, write low,
//                      write high; ends once low is no longer below high
//   linear search      per entry inspected: read, then compare; then emit
//   binary search      per probe: probe read, then move; then emit
//                      (at most 11 probes)
//   The table memory has one read port with registered data, so every
//   table read costs a step of its own.
// Reset clears the sequencer, the response valid flag and the length
//   register; table contents stay undefined until written and are not
//   cleared. A stalled response holds in the output register; the
//   sequencer waits on its emit step until that register frees up.
// ----------------------------------------------------------------------------
module array_reverse_and_search_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: used_length
  input  logic                                cfg_we_i,
  input  logic [arsrch_pkg::LenW-1:0]         cfg_wdata_i,
  // request
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [9:0] entry_index, [41:10] data_value, [47:42] zero
  input  logic [arsrch_pkg::InTdataW-1:0]     s_axis_tdata_i,
  // [1:0] command
  input  logic [arsrch_pkg::CmdW-1:0]         s_axis_tuser_i,
  // response
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [0] found, [7:1] zero
  output logic [arsrch_pkg::OutTdataW-1:0]    m_axis_tdata_o
);

  localparam int unsigned AddrW = arsrch_pkg::AddrW;
  localparam int unsigned LenW  = arsrch_pkg::LenW;
  localparam int unsigned DataW = arsrch_pkg::DataW;

  arsrch_pkg::pc_t    pc_q, pc_d;
  arsrch_pkg::uword_t uw;

  logic [LenW-1:0]  used_q;
  logic [LenW-1:0]  live_n;
  logic [LenW-1:0]  lo_q, lo_d;
  logic [LenW-1:0]  hi_q, hi_d;
  logic [AddrW-1:0] mid_q;
  logic [AddrW-1:0] idx_q;
  logic [DataW-1:0] key_q;
  logic [DataW-1:0] tmp_q;
  logic [DataW-1:0] rdata_q;
  logic             m_valid_q;
  logic             found_q;

  logic [LenW:0]    mid_sum;
  logic             req_acc;
  logic             out_free;
  logic             cond_hit;
  logic             emit;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  logic [DataW-1:0] mem [arsrch_pkg::TableDepth];

  assign uw       = arsrch_pkg::ucode_rom(pc_q);
  assign req_acc  = s_axis_tvalid_i && (pc_q == arsrch_pkg::StIdle);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};

  assign live_n = (used_q > LenW'(arsrch_pkg::TableDepth)) ?
                  LenW'(arsrch_pkg::TableDepth) : used_q;

  assign s_axis_tready_o = (pc_q == arsrch_pkg::StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(arsrch_pkg::OutTdataW-1){1'b0}}, found_q};

  // jump condition of the current control word
  always_comb begin
    case (uw.cond)
      arsrch_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      arsrch_pkg::COND_DISPATCH: cond_hit = req_acc;
      arsrch_pkg::COND_NOT_LT:   cond_hit = !arsrch_pkg::bound_lt(lo_q, hi_q);
      arsrch_pkg::COND_NOT_LE:   cond_hit = !arsrch_pkg::bound_le(lo_q, hi_q);
      arsrch_pkg::COND_EQ:       cond_hit = (rdata_q == key_q);
      arsrch_pkg::COND_OUT_BUSY: cond_hit = !out_free;
      default:                   cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    if (uw.cond == arsrch_pkg::COND_DISPATCH) begin
      pc_d = req_acc ? arsrch_pkg::entry_step(arsrch_pkg::cmd_e'(s_axis_tuser_i))
                     : uw.jn;
    end else begin
      pc_d = cond_hit ? uw.jt : uw.jn;
    end
  end

  // datapath controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lo_q[AddrW-1:0];
    mem_wdata = rdata_q;
    mem_raddr = lo_q[AddrW-1:0];
    lo_d      = lo_q;
    hi_d      = hi_q;
    emit      = 1'b0;
    case (uw.act)
      arsrch_pkg::ACT_NONE: begin
        if (req_acc) begin
          lo_d = '0;
          hi_d = live_n - LenW'(1);
        end
      end
      arsrch_pkg::ACT_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = key_q;
      end
      arsrch_pkg::ACT_RD_LO: begin
        mem_raddr = lo_q[AddrW-1:0];
      end
      arsrch_pkg::ACT_RD_HI: begin
        mem_raddr = hi_q[AddrW-1:0];
      end
      arsrch_pkg::ACT_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AddrW-1:0];
        mem_wdata = rdata_q;
      end
      arsrch_pkg::ACT_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q[AddrW-1:0];
        mem_wdata = tmp_q;
        lo_d      = lo_q + LenW'(1);
        hi_d      = hi_q - LenW'(1);
      end
      arsrch_pkg::ACT_LO_INC: begin
        lo_d = lo_q + LenW'(1);
      end
      arsrch_pkg::ACT_PROBE: begin
        mem_raddr = mid_sum[AddrW:1];
      end
      arsrch_pkg::ACT_MOVE: begin
        // signed compare of the probed word against the key
        if ($signed(rdata_q) < $signed(key_q)) begin
          lo_d = {1'b0, mid_q} + LenW'(1);
        end else begin
          hi_d = {1'b0, mid_q} - LenW'(1);
        end
      end
      arsrch_pkg::ACT_EMIT_HIT,
      arsrch_pkg::ACT_EMIT_MISS: begin
        emit = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= arsrch_pkg::StIdle;
      used_q    <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      if (cfg_we_i) begin
        used_q <= cfg_wdata_i;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      idx_q <= s_axis_tdata_i[AddrW-1:0];
      key_q <= s_axis_tdata_i[AddrW+DataW-1:AddrW];
    end
    if (uw.act == arsrch_pkg::ACT_PROBE) begin
      mid_q <= mid_sum[AddrW:1];
    end
    // hold the low entry while the high entry is read
    if (uw.act == arsrch_pkg::ACT_RD_HI) begin
      tmp_q <= rdata_q;
    end
    if (emit) begin
      found_q <= (uw.act == arsrch_pkg::ACT_EMIT_HIT);
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives write, reverse and both search commands into the table engine and
// checks every found bit against a behavioral table copy or a fixed expected
// value, with random request gaps, response stalls and several table lengths.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TableDepth = arsrch_pkg::TableDepth;
  localparam int unsigned AddrW      = arsrch_pkg::AddrW;
  localparam int unsigned LenW       = arsrch_pkg::LenW;
  localparam int unsigned DataW      = arsrch_pkg::DataW;
  localparam int unsigned CmdW       = arsrch_pkg::CmdW;
  localparam int unsigned InTdataW   = arsrch_pkg::InTdataW;
  localparam int unsigned OutTdataW  = arsrch_pkg::OutTdataW;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DirCount   = 24;
  localparam int unsigned PhaseCount = 10;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [LenW-1:0]      cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  // [9:0] entry_index, [41:10] data_value, [47:42] zero
  logic [InTdataW-1:0]  s_axis_tdata_i;
  // [1:0] command
  logic [CmdW-1:0]      s_axis_tuser_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b1;
  // [0] found, [7:1] zero
  logic [OutTdataW-1:0] m_axis_tdata_o;

  array_reverse_and_search_engine uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the engine state
  logic [DataW-1:0] word_mirror [TableDepth];
  bit               entry_set   [TableDepth];
  logic [LenW-1:0]  length_reg = '0;
  logic [LenW-1:0]  probe_lo   = '0;
  logic [LenW-1:0]  probe_hi   = '0;

  bit          pending_found [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  bit          calm           = 1'b0;

  typedef struct packed {
    bit                 is_cfg;
    logic [LenW-1:0]    len;
    arsrch_pkg::cmd_e   cmd;
    logic [AddrW-1:0]   idx;
    logic [DataW-1:0]   val;
    bit                 typed;
    bit                 typed_found;
  } dir_row_t;

  dir_row_t dir_rows [DirCount] = '{
    // empty table after reset: both searches miss, reverse is a no-op
    '{1'b0, 11'd0, arsrch_pkg::CMD_LINEAR,  10'd0,    32'h0000_0000, 1'b1, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h0000_0000, 1'b1, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_REVERSE, 10'd0,    32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_WRITE,   10'd0,    32'h8000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_WRITE,   10'd1,    32'hFFFF_FFFF, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_WRITE,   10'd2,    32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_WRITE,   10'd3,    32'h7FFF_FFFF, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_WRITE,   10'd1023, 32'h5A5A_A5A5, 1'b0, 1'b0},
    '{1'b1, 11'd4, arsrch_pkg::CMD_WRITE,   10'd0,    32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h8000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h7FFF_FFFF, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h0000_0005, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_LINEAR,  10'd0,    32'h7FFF_FFFF, 1'b0, 1'b0},
    // key sits past the used length
    '{1'b0, 11'd0, arsrch_pkg::CMD_LINEAR,  10'd0,    32'h5A5A_A5A5, 1'b1, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_REVERSE, 10'd0,    32'h0000_0000, 1'b0, 1'b0},
    // descending table: the probe sequence decides
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'hFFFF_FFFF, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h8000_0000, 1'b0, 1'b0},
    '{1'b1, 11'd1, arsrch_pkg::CMD_WRITE,   10'd0,    32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_LINEAR,  10'd0,    32'h7FFF_FFFF, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_REVERSE, 10'd0,    32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h7FFF_FFFF, 1'b0, 1'b0},
    '{1'b1, 11'd0, arsrch_pkg::CMD_WRITE,   10'd0,    32'h0000_0000, 1'b0, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_LINEAR,  10'd0,    32'h5A5A_A5A5, 1'b1, 1'b0},
    '{1'b0, 11'd0, arsrch_pkg::CMD_BINARY,  10'd0,    32'h5A5A_A5A5, 1'b1, 1'b0}
  };

  // lengths of the random phases; zero runs the empty table
  int unsigned phase_len [PhaseCount] = '{3, 1, 16, 2, 40, 7, 150, 0, 9, 31};

  function automatic int unsigned live_count();
    return (length_reg > LenW'(TableDepth)) ? TableDepth : 32'(length_reg);
  endfunction

  function automatic void apply_to_mirror(input arsrch_pkg::cmd_e cmd,
                                          input logic [AddrW-1:0] idx,
                                          input logic [DataW-1:0] val,
                                          output bit has_result, output bit hit);
    int unsigned      n;
    int               lo;
    int               hi;
    int               mid;
    logic [DataW-1:0] t;
    n          = live_count();
    has_result = 1'b0;
    hit        = 1'b0;
    case (cmd)
      arsrch_pkg::CMD_WRITE: begin
        word_mirror[idx] = val;
        entry_set[idx]   = 1'b1;
      end
      arsrch_pkg::CMD_REVERSE: begin
        for (int i = 0; i < int'(n / 2); i++) begin
          t                  = word_mirror[i];
          word_mirror[i]     = word_mirror[n-1-i];
          word_mirror[n-1-i] = t;
        end
      end
      arsrch_pkg::CMD_LINEAR: begin
        has_result = 1'b1;
        for (int i = 0; i < int'(n); i++) begin
          if (word_mirror[i] == val) hit = 1'b1;
        end
      end
      default: begin
        has_result = 1'b1;
        lo = 0;
        hi = int'(n) - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (word_mirror[mid] == val) begin
            hit = 1'b1;
            break;
          end
          if ($signed(word_mirror[mid]) < $signed(val)) lo = mid + 1;
          else hi = mid - 1;
        end
        probe_lo = lo[LenW-1:0];
        probe_hi = hi[LenW-1:0];
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic issue(input arsrch_pkg::cmd_e cmd, input logic [AddrW-1:0] idx,
                       input logic [DataW-1:0] val, input bit typed, input bit typed_found);
    bit has_result;
    bit hit;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InTdataW-AddrW-DataW){1'b0}}, val, idx};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    apply_to_mirror(cmd, idx, val, has_result, hit);
    if (has_result) pending_found.push_back(typed ? typed_found : hit);
  endtask

  // waits out the last request, which may still be a reverse with no response
  task automatic set_length(input logic [LenW-1:0] len);
    s_axis_tvalid_i <= 1'b0;
    while (pending_found.size() != 0) @(posedge clk_i);
    repeat (2 * live_count() + 64) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    length_reg  = len;
  endtask

  always @(posedge clk_i) begin
    if (calm || !rst_ni) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= (stall_left == 1);
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left      <= $urandom_range(1, 10);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_found.size() == 0) begin
        report_mismatch("response with no search pending");
      end else begin
        want = pending_found.pop_front();
        if (m_axis_tdata_o[0] !== want)
          report_mismatch($sformatf("found is %b, expected %b", m_axis_tdata_o[0], want));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned      live;
    int unsigned      roll;
    bit               refill;
    logic [DataW-1:0] key;
    int               fill_vals [$];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = arsrch_pkg::CMD_WRITE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) set_length(dir_rows[r].len);
      else issue(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].val,
                 dir_rows[r].typed, dir_rows[r].typed_found);
    end

    foreach (phase_len[p]) begin
      set_length(phase_len[p][LenW-1:0]);
      calm = (p >= PhaseCount - 2);
      live = live_count();
      // every entry in use must be written before anything reads it
      refill = (live <= 256);
      for (int i = 0; i < int'(live); i++) begin
        if (!entry_set[i]) refill = 1'b1;
      end
      if (refill) begin
        fill_vals.delete();
        repeat (live) fill_vals.push_back(int'($urandom));
        fill_vals.sort();
        foreach (fill_vals[i])
          issue(arsrch_pkg::CMD_WRITE, AddrW'(i), fill_vals[i], 1'b0, 1'b0);
      end
      repeat (30) begin
        roll = $urandom_range(0, 99);
        key  = $urandom;
        if (live != 0 && $urandom_range(0, 3) != 0) begin
          key = word_mirror[$urandom_range(0, live - 1)];
          if ($urandom_range(0, 2) == 0) key = key + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
        end
        if (roll < 8)
          issue(arsrch_pkg::CMD_WRITE, AddrW'($urandom), $urandom, 1'b0, 1'b0);
        else if (roll < 16)
          issue(arsrch_pkg::CMD_REVERSE, AddrW'($urandom), $urandom, 1'b0, 1'b0);
        else if (roll < 58)
          issue(arsrch_pkg::CMD_BINARY, AddrW'($urandom), key, 1'b0, 1'b0);
        else
          issue(arsrch_pkg::CMD_LINEAR, AddrW'($urandom), key, 1'b0, 1'b0);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_found.size() != 0) @(posedge clk_i);
    repeat (2 * live_count() + 64) @(posedge clk_i);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
